>>> hdl/gicr_pkg.sv
// ----------------------------------------------------------------------------
// gicr_pkg
// Shared widths, register indexes and reset values for the grid index to
// coordinate and radius block.
// ----------------------------------------------------------------------------
package gicr_pkg;

  localparam int REG_W     = 11;  // size register width
  localparam int IDX_W     = 30;  // flat cell index width
  localparam int COORD_W   = 10;  // coordinate field width
  localparam int RAD_W     = 20;  // squared radius field width
  localparam int CFG_IDX_W = 2;   // register index width
  localparam int DIV_STEPS = 4;   // quotient bits resolved per divider stage

  localparam logic [REG_W-1:0] SIZE_RST = REG_W'(64);
  localparam logic [RAD_W-1:0] RAD_MAX  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_reg_t;

endpackage

>>> hdl/grid_index_to_coord_radius.sv
// ----------------------------------------------------------------------------
// grid_index_to_coord_radius
// Splits a flat 3-D grid cell index (x fastest, then y, then z) into
// coordinates and the squared distance from the grid centre.
// ----------------------------------------------------------------------------
// One item is taken in every cycle (busy stays low) and each result appears
// on the out_ ports for one cycle with out_valid. Each item passes through
// two pipelined dividers, which resolve four quotient bits per stage (index
// by plane size, then remainder by row length), followed by three stages for
// the squared radius. The receiver must take every result. Sizes of zero act
// as one and sizes above MAX_AXIS act as MAX_AXIS. Write the size registers
// only while no item is in flight.
// ----------------------------------------------------------------------------
module grid_index_to_coord_radius #(
  parameter int MAX_AXIS = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [gicr_pkg::IDX_W-1:0]       in_cell_index,
  output logic                             out_valid,
  output logic [gicr_pkg::COORD_W-1:0]     out_coord_x,
  output logic [gicr_pkg::COORD_W-1:0]     out_coord_y,
  output logic [gicr_pkg::COORD_W-1:0]     out_coord_z,
  output logic [gicr_pkg::RAD_W-1:0]       out_radius_sq,
  output logic                             out_out_of_range,
  input  logic                             cfg_wr_en,
  input  logic [gicr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gicr_pkg::REG_W-1:0]       cfg_wdata
);

  localparam int AW    = $clog2(MAX_AXIS + 1);
  localparam int PW    = 2 * AW;
  localparam int CW    = (AW > gicr_pkg::REG_W) ? AW : gicr_pkg::REG_W;
  localparam int NSTG1 = (gicr_pkg::IDX_W + gicr_pkg::DIV_STEPS - 1) / gicr_pkg::DIV_STEPS;
  localparam int NSTG2 = (PW + gicr_pkg::DIV_STEPS - 1) / gicr_pkg::DIV_STEPS;
  localparam int LAT   = NSTG1 + NSTG2 + 3;

  function automatic logic [AW-1:0] eff_size(input logic [gicr_pkg::REG_W-1:0] r);
    logic [CW-1:0] rw;
    rw = CW'(r);
    if (rw == '0) begin
      return AW'(1);
    end else if (rw > CW'(MAX_AXIS)) begin
      return AW'(MAX_AXIS);
    end else begin
      return AW'(rw);
    end
  endfunction

  logic [gicr_pkg::REG_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [gicr_pkg::REG_W-1:0] size_x_nxt, size_y_nxt, size_z_nxt;
  logic [AW-1:0]              nx, ny, nz;
  logic [PW-1:0]              plane_r;

  always_comb begin
    size_x_nxt = size_x_r;
    size_y_nxt = size_y_r;
    size_z_nxt = size_z_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        gicr_pkg::CFG_SIZE_X: size_x_nxt = cfg_wdata;
        gicr_pkg::CFG_SIZE_Y: size_y_nxt = cfg_wdata;
        gicr_pkg::CFG_SIZE_Z: size_z_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // keep the plane size in step with the size registers, so an item taken
  // right after a write already divides by the new plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= gicr_pkg::SIZE_RST;
      size_y_r <= gicr_pkg::SIZE_RST;
      size_z_r <= gicr_pkg::SIZE_RST;
      plane_r  <= PW'(eff_size(gicr_pkg::SIZE_RST)) * PW'(eff_size(gicr_pkg::SIZE_RST));
    end else begin
      size_x_r <= size_x_nxt;
      size_y_r <= size_y_nxt;
      size_z_r <= size_z_nxt;
      plane_r  <= PW'(eff_size(size_x_nxt)) * PW'(eff_size(size_y_nxt));
    end
  end

  assign nx = eff_size(size_x_r);
  assign ny = eff_size(size_y_r);
  assign nz = eff_size(size_z_r);

  // the pipeline takes an item in every cycle
  assign busy = 1'b0;

  // index / plane
  logic                       d1_valid;
  logic [gicr_pkg::IDX_W-1:0] d1_quot;
  logic [PW-1:0]              d1_rem;

  gicr_div #(
    .NUM_W  (gicr_pkg::IDX_W),
    .DEN_W  (PW),
    .STEP_N (gicr_pkg::DIV_STEPS)
  ) u_div_plane (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_num    (in_cell_index),
    .den       (plane_r),
    .out_valid (d1_valid),
    .out_quot  (d1_quot),
    .out_rem   (d1_rem)
  );

  // saturate z against the grid depth
  logic          z_oor;
  logic [AW-1:0] z_sat;

  always_comb begin
    z_oor = d1_quot >= gicr_pkg::IDX_W'(nz);
    z_sat = z_oor ? (nz - AW'(1)) : d1_quot[AW-1:0];
  end

  // remainder / row length
  logic          d2_valid;
  logic [PW-1:0] d2_quot;
  logic [AW-1:0] d2_rem;

  gicr_div #(
    .NUM_W  (PW),
    .DEN_W  (AW),
    .STEP_N (gicr_pkg::DIV_STEPS)
  ) u_div_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d1_valid),
    .in_num    (d1_rem),
    .den       (nx),
    .out_valid (d2_valid),
    .out_quot  (d2_quot),
    .out_rem   (d2_rem)
  );

  // hold z and the range flag alongside the row divider
  logic [AW-1:0] zd_r   [NSTG2];
  logic          oord_r [NSTG2];

  always_ff @(posedge clk) begin
    zd_r[0]   <= z_sat;
    oord_r[0] <= z_oor;
    for (int i = 1; i < NSTG2; i++) begin
      zd_r[i]   <= zd_r[i-1];
      oord_r[i] <= oord_r[i-1];
    end
  end

  gicr_radius #(
    .AW (AW)
  ) u_radius (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (d2_valid),
    .in_x       (d2_rem),
    .in_y       (d2_quot[AW-1:0]),
    .in_z       (zd_r[NSTG2-1]),
    .in_oor     (oord_r[NSTG2-1]),
    .nx         (nx),
    .ny         (ny),
    .nz         (nz),
    .out_valid  (out_valid),
    .out_x      (out_coord_x),
    .out_y      (out_coord_y),
    .out_z      (out_coord_z),
    .out_radius (out_radius_sq),
    .out_oor    (out_out_of_range)
  );

  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("item lost in pipeline");

  a_x_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_coord_x) < int'(nx)))
    else $error("x coordinate beyond row length");

  a_z_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_coord_z == gicr_pkg::COORD_W'(nz - AW'(1))))
    else $error("z not saturated on out-of-range index");

  a_z_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range) |-> (int'(out_coord_z) < int'(nz)))
    else $error("z beyond grid depth without range flag");

endmodule

>>> hdl/gicr_div.sv
// ----------------------------------------------------------------------------
// gicr_div
// Pipelined restoring divider: one item per cycle, STEP_N quotient bits a stage.
// The user, not the block, keeps the divisor static while items are in flight.
// ----------------------------------------------------------------------------
module gicr_div #(
  parameter int NUM_W  = 30,
  parameter int DEN_W  = 22,
  parameter int STEP_N = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] den,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quot,
  output logic [DEN_W-1:0] out_rem
);

  localparam int NSTG = (NUM_W + STEP_N - 1) / STEP_N;

  logic             valid_r [NSTG];
  logic [NUM_W-1:0] shift_r [NSTG];  // dividend bits out at the top, quotient in
  logic [DEN_W-1:0] part_r  [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic             vin;
    logic [NUM_W-1:0] shin;
    logic [DEN_W-1:0] ptin;
    logic [NUM_W-1:0] shift_nxt;
    logic [DEN_W-1:0] part_nxt;

    if (s == 0) begin : g_head
      assign vin  = in_valid;
      assign shin = in_num;
      assign ptin = '0;
    end else begin : g_body
      assign vin  = valid_r[s-1];
      assign shin = shift_r[s-1];
      assign ptin = part_r[s-1];
    end

    always_comb begin
      logic [DEN_W:0] acc;
      logic           qb;
      shift_nxt = shin;
      part_nxt  = ptin;
      acc       = '0;
      qb        = 1'b0;
      for (int j = 0; j < STEP_N; j++) begin
        if (s * STEP_N + j < NUM_W) begin
          acc = {part_nxt, shift_nxt[NUM_W-1]};
          if (acc >= {1'b0, den}) begin
            acc = acc - {1'b0, den};
            qb  = 1'b1;
          end else begin
            qb  = 1'b0;
          end
          part_nxt  = acc[DEN_W-1:0];
          shift_nxt = {shift_nxt[NUM_W-2:0], qb};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else begin
        valid_r[s] <= vin;
      end
      shift_r[s] <= shift_nxt;
      part_r[s]  <= part_nxt;
    end
  end

  assign out_valid = valid_r[NSTG-1];
  assign out_quot  = shift_r[NSTG-1];
  assign out_rem   = part_r[NSTG-1];

endmodule

>>> hdl/gicr_radius.sv
// ----------------------------------------------------------------------------
// gicr_radius
// Three-stage squared distance from the grid centre: offsets, squares, then
// saturating sum. Coordinates are carried alongside and trimmed to field width.
// ----------------------------------------------------------------------------
module gicr_radius #(
  parameter int AW = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [AW-1:0]               in_x,
  input  logic [AW-1:0]               in_y,
  input  logic [AW-1:0]               in_z,
  input  logic                        in_oor,
  input  logic [AW-1:0]               nx,
  input  logic [AW-1:0]               ny,
  input  logic [AW-1:0]               nz,
  output logic                        out_valid,
  output logic [gicr_pkg::COORD_W-1:0] out_x,
  output logic [gicr_pkg::COORD_W-1:0] out_y,
  output logic [gicr_pkg::COORD_W-1:0] out_z,
  output logic [gicr_pkg::RAD_W-1:0]   out_radius,
  output logic                        out_oor
);

  localparam int SQ_W  = 2 * AW;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > gicr_pkg::RAD_W) ? SUM_W : gicr_pkg::RAD_W;

  function automatic logic [AW-1:0] abs_off(input logic [AW-1:0] c,
                                            input logic [AW-1:0] n);
    logic [AW-1:0] mid;
    mid = n >> 1;
    return (c >= mid) ? (c - mid) : (mid - c);
  endfunction

  logic          v1_r, v2_r, v3_r;
  logic [AW-1:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic          oor1_r, oor2_r, oor3_r;
  logic [AW-1:0] dx_r, dy_r, dz_r;
  logic [SQ_W-1:0] sx_r, sy_r, sz_r;
  logic [gicr_pkg::COORD_W-1:0] x3_r, y3_r, z3_r;
  logic [gicr_pkg::RAD_W-1:0]   rad_r;
  logic [SUM_W-1:0]             sum_nxt;
  logic [gicr_pkg::RAD_W-1:0]   rad_nxt;

  always_comb begin
    sum_nxt = SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
    if (CMP_W'(sum_nxt) > CMP_W'(gicr_pkg::RAD_MAX)) begin
      rad_nxt = gicr_pkg::RAD_MAX;
    end else begin
      rad_nxt = gicr_pkg::RAD_W'(sum_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    // offsets
    dx_r   <= abs_off(in_x, nx);
    dy_r   <= abs_off(in_y, ny);
    dz_r   <= abs_off(in_z, nz);
    x1_r   <= in_x;
    y1_r   <= in_y;
    z1_r   <= in_z;
    oor1_r <= in_oor;
    // squares
    sx_r   <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sy_r   <= SQ_W'(dy_r) * SQ_W'(dy_r);
    sz_r   <= SQ_W'(dz_r) * SQ_W'(dz_r);
    x2_r   <= x1_r;
    y2_r   <= y1_r;
    z2_r   <= z1_r;
    oor2_r <= oor1_r;
    // saturating sum, trim coordinates to field width
    rad_r  <= rad_nxt;
    x3_r   <= gicr_pkg::COORD_W'(x2_r);
    y3_r   <= gicr_pkg::COORD_W'(y2_r);
    z3_r   <= gicr_pkg::COORD_W'(z2_r);
    oor3_r <= oor2_r;
  end

  assign out_valid  = v3_r;
  assign out_x      = x3_r;
  assign out_y      = y3_r;
  assign out_z      = z3_r;
  assign out_radius = rad_r;
  assign out_oor    = oor3_r;

endmodule
